>>> design/ftl_pkg.sv
package ftl_pkg;

    // field and datapath widths
    localparam int FORCE_W = 10;
    localparam int LVL_W   = 8;
    localparam int SLOPE_W = 16;
    localparam int CFG_W   = 16;
    localparam int ERR_W   = FORCE_W + 1;
    // signed dividend / quotient width of the shared divider
    localparam int ACC_W   = 27;
    // signed divisor width of the shared divider (magnitude up to 1024)
    localparam int DVS_W   = 12;

    localparam int CALIB_TICKS_DEF = 250;

    // arithmetic constants
    localparam logic signed [ACC_W-1:0] SLOPE_NUM  = 25500;
    localparam logic signed [ACC_W-1:0] ROUND_UP   = 99;
    localparam logic signed [DVS_W-1:0] LEVEL_DIV  = 100;
    localparam logic signed [DVS_W-1:0] FULL_SCALE = 1024;
    localparam logic signed [DVS_W-1:0] ONE_SPAN   = 1;
    localparam logic signed [ACC_W-1:0] LVL_MAX    = 255;

    // divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [ACC_W-1:0]  dividend;
        logic signed [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [ACC_W-1:0]  quot;
    } t_div_rsp;

    // saturate a signed value into a light level
    function automatic logic [LVL_W-1:0] clamp_level(input logic signed [ACC_W-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > LVL_MAX) begin
            return '1;
        end else begin
            return v[LVL_W-1:0];
        end
    endfunction

endpackage

>>> design/force_target_led_feedback_core.sv
// Force target light feedback core.
// Input channel (i_in_valid / o_in_ready) carries one 10 ms tick: a force
// sample and the button level (0 = pressed). Output channel (o_out_valid /
// i_out_ready) returns one transaction per tick: the three PWM duties, the
// target divided by four and the mode after the tick.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high (0 bias_force, 1 press_threshold, 2 target_offset); write only while
// the block is idle.
// Sequencing: standby and ordinary calibration ticks go from accept straight
// to S_DONE. The last calibration tick and a game tick both run two passes of
// the shared radix-2 divider (each a start state plus a wait state), and a
// game tick also first passes through the slope multiplier state S_MUL.
// One tick is processed at a time; o_in_ready is high only while the
// sequencer is idle. The result sits in an output register, so the next
// tick is taken while it waits; a stalled receiver holds a finished
// result until the output register frees up.
// Reset (synchronous, active low) returns to standby with the target at
// 500, peak at 1024, slopes and lights at zero and default registers.
module force_target_led_feedback_core
    import ftl_pkg::*;
#(
    parameter int CALIB_TICKS = CALIB_TICKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // tick input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FORCE_W-1:0] i_force_sample,
    input  logic               i_button_level,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LVL_W-1:0]   o_less_level,
    output logic [LVL_W-1:0]   o_target_level,
    output logic [LVL_W-1:0]   o_more_level,
    output logic [LVL_W-1:0]   o_target_out,
    output logic [1:0]         o_mode,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam logic [1:0] CFG_BIAS   = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;

    localparam logic [4:0]         PHASE_LAST   = 5'd19;
    localparam logic [4:0]         PHASE_HALF   = 5'd10;
    localparam logic [7:0]         CNT_MAX      = 8'd255;
    localparam logic [LVL_W-1:0]   BLINK_LEVEL  = 8'd10;
    localparam logic [FORCE_W:0]   PEAK_RESET   = 11'd1024;
    localparam logic [FORCE_W-1:0] TARGET_RESET = 10'd500;
    localparam logic [7:0]         THR_RESET    = 8'd25;

    typedef enum logic [1:0] {
        MODE_STANDBY   = 2'd0,
        MODE_CALIBRATE = 2'd1,
        MODE_GAME      = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_GDIV1,
        S_GWAIT1,
        S_GDIV2,
        S_GWAIT2,
        S_SDIV1,
        S_SWAIT1,
        S_SDIV2,
        S_SWAIT2,
        S_DONE
    } t_state;

    // configuration
    logic [FORCE_W-1:0]        r_bias;
    logic [7:0]                r_thresh;
    logic signed [CFG_W-1:0]   r_off;

    // block state
    t_state                    r_state;
    t_mode                     r_mode;
    logic [4:0]                r_phase;
    logic [7:0]                r_press_cnt;
    logic [7:0]                r_calib_cnt;
    logic [FORCE_W:0]          r_peak;
    logic [FORCE_W-1:0]        r_target;
    logic signed [SLOPE_W-1:0] r_less_slope;
    logic signed [SLOPE_W-1:0] r_more_slope;
    logic [LVL_W-1:0]          r_less;
    logic [LVL_W-1:0]          r_tgt;
    logic [LVL_W-1:0]          r_more;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ACC_W-1:0]   r_prod;

    // output register
    logic                      r_out_valid;
    logic [LVL_W-1:0]          r_out_less;
    logic [LVL_W-1:0]          r_out_tgt;
    logic [LVL_W-1:0]          r_out_more;
    logic [LVL_W-1:0]          r_out_target;
    logic [1:0]                r_out_mode;

    // accept-time next values
    logic                      w_accept;
    logic [4:0]                n_phase;
    logic [FORCE_W:0]          w_mirror_sum;
    logic [LVL_W-1:0]          w_mirror;
    logic [7:0]                w_press_inc;
    logic                      w_press;
    logic [7:0]                n_press_cnt;
    logic [7:0]                n_calib_cnt;
    logic [FORCE_W:0]          n_peak;
    logic [FORCE_W+2:0]        w_tri;
    logic                      w_calib_end;
    logic signed [ERR_W-1:0]   n_err;

    // arithmetic datapath
    logic signed [SLOPE_W-1:0] w_slope;
    logic signed [ACC_W-1:0]   w_slope_x;
    logic signed [ACC_W-1:0]   w_err_x;
    logic signed [ACC_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]   w_off_x;
    logic signed [ACC_W-1:0]   w_bias_x;
    logic signed [ACC_W-1:0]   w_q_bias;
    logic signed [DVS_W-1:0]   w_target_x;
    logic signed [DVS_W-1:0]   w_span_max;
    logic signed [DVS_W-1:0]   w_span_min;
    logic [LVL_W-1:0]          w_side_lvl;

    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // tick phase wraps after 19
    assign n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;

    // force mirrored onto a light, rounded up and saturated
    assign w_mirror_sum = {1'b0, i_force_sample} + (FORCE_W+1)'(3);
    assign w_mirror     = w_mirror_sum[FORCE_W] ? '1 : w_mirror_sum[FORCE_W-1:2];

    // button press counting
    assign w_press_inc = (!i_button_level && r_press_cnt != CNT_MAX) ?
                         r_press_cnt + 1'b1 : r_press_cnt;
    assign w_press     = w_press_inc > r_thresh;
    assign n_press_cnt = w_press ? '0 : w_press_inc;

    // calibration tracking, new target = (3*peak + 3) / 4
    assign n_calib_cnt = (r_calib_cnt != CNT_MAX) ? r_calib_cnt + 1'b1 : r_calib_cnt;
    assign n_peak      = ({1'b0, i_force_sample} > r_peak) ? {1'b0, i_force_sample} : r_peak;
    assign w_tri       = {2'b00, n_peak} + {1'b0, n_peak, 1'b0} + (FORCE_W+3)'(3);
    assign w_calib_end = n_calib_cnt >= 8'(CALIB_TICKS);

    assign n_err = signed'({1'b0, r_target}) - signed'({1'b0, i_force_sample});

    // slope times error, registered in S_MUL
    assign w_slope   = r_err[ERR_W-1] ? r_less_slope : r_more_slope;
    assign w_slope_x = ACC_W'(w_slope);
    assign w_err_x   = ACC_W'(r_err);
    assign w_prod    = w_slope_x * w_err_x;

    assign w_off_x    = ACC_W'(r_off);
    assign w_bias_x   = signed'(ACC_W'(r_bias));
    assign w_q_bias   = w_div_rsp.quot - w_bias_x;
    assign w_side_lvl = clamp_level(w_q_bias);

    // error spans, a zero span divides as one
    assign w_target_x = signed'(DVS_W'(r_target));
    assign w_span_max = w_target_x - signed'(DVS_W'(r_bias));
    assign w_span_min = w_target_x - FULL_SCALE;

    // divider operand select
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = SLOPE_NUM;
        w_div_req.divisor  = LEVEL_DIV;
        case (r_state)
            S_GDIV1: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_off_x - r_prod + ROUND_UP;
            end
            S_GDIV2: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_prod + ROUND_UP;
            end
            S_SDIV1: begin
                w_div_req.start   = 1'b1;
                w_div_req.divisor = (w_span_max == '0) ? ONE_SPAN : w_span_max;
            end
            S_SDIV2: begin
                w_div_req.start   = 1'b1;
                w_div_req.divisor = (w_span_min == '0) ? ONE_SPAN : w_span_min;
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    ftl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias   <= '0;
            r_thresh <= THR_RESET;
            r_off    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIAS:   r_bias   <= i_cfg_data[FORCE_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_data[7:0];
                CFG_OFFSET: r_off    <= signed'(i_cfg_data);
                default:    r_bias   <= r_bias;
            endcase
        end
    end

    // sequencer, block state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_STANDBY;
            r_phase      <= '0;
            r_press_cnt  <= '0;
            r_calib_cnt  <= '0;
            r_peak       <= PEAK_RESET;
            r_target     <= TARGET_RESET;
            r_less_slope <= '0;
            r_more_slope <= '0;
            r_less       <= '0;
            r_tgt        <= '0;
            r_more       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_phase <= n_phase;
                        r_err   <= n_err;
                        case (r_mode)
                            MODE_CALIBRATE: begin
                                r_calib_cnt <= n_calib_cnt;
                                r_peak      <= n_peak;
                                r_less      <= w_mirror;
                                r_tgt       <= w_mirror;
                                r_more      <= w_mirror;
                                if (w_calib_end) begin
                                    r_target <= w_tri[FORCE_W+1:2];
                                    r_mode   <= MODE_GAME;
                                    r_state  <= S_SDIV1;
                                end else begin
                                    r_state  <= S_DONE;
                                end
                            end
                            MODE_GAME: begin
                                r_press_cnt <= n_press_cnt;
                                if (w_press) begin
                                    r_peak      <= '0;
                                    r_calib_cnt <= '0;
                                    r_mode      <= MODE_CALIBRATE;
                                end
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_press_cnt <= n_press_cnt;
                                r_tgt       <= w_mirror;
                                // blink: more light at mid cycle, less at wrap
                                if (n_phase == '0) begin
                                    r_more <= '0;
                                    r_less <= BLINK_LEVEL;
                                end else if (n_phase == PHASE_HALF) begin
                                    r_more <= BLINK_LEVEL;
                                    r_less <= '0;
                                end
                                if (w_press) begin
                                    r_less      <= '0;
                                    r_tgt       <= '0;
                                    r_more      <= '0;
                                    r_peak      <= '0;
                                    r_calib_cnt <= '0;
                                    r_mode      <= MODE_CALIBRATE;
                                end
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_GDIV1;
                end
                S_GDIV1: r_state <= S_GWAIT1;
                S_GWAIT1: begin
                    if (w_div_rsp.done) begin
                        r_tgt   <= clamp_level(w_div_rsp.quot);
                        r_state <= S_GDIV2;
                    end
                end
                S_GDIV2: r_state <= S_GWAIT2;
                S_GWAIT2: begin
                    if (w_div_rsp.done) begin
                        if (r_err[ERR_W-1]) begin
                            r_less <= w_side_lvl;
                            r_more <= '0;
                        end else begin
                            r_more <= w_side_lvl;
                            r_less <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SDIV1: r_state <= S_SWAIT1;
                S_SWAIT1: begin
                    if (w_div_rsp.done) begin
                        r_more_slope <= w_div_rsp.quot[SLOPE_W-1:0];
                        r_state      <= S_SDIV2;
                    end
                end
                S_SDIV2: r_state <= S_SWAIT2;
                S_SWAIT2: begin
                    if (w_div_rsp.done) begin
                        r_less_slope <= w_div_rsp.quot[SLOPE_W-1:0];
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // load the result once the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_less   <= r_less;
                        r_out_tgt    <= r_tgt;
                        r_out_more   <= r_more;
                        r_out_target <= r_target[FORCE_W-1:2];
                        r_out_mode   <= r_mode;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_less_level   = r_out_less;
    assign o_target_level = r_out_tgt;
    assign o_more_level   = r_out_more;
    assign o_target_out   = r_out_target;
    assign o_mode         = r_out_mode;

    // divider is never busy while a new tick can be taken
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_rsp.busy)
        else $error("divider busy while sequencer idle");

    // divider completions only land in a wait state
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_GWAIT1 || r_state == S_GWAIT2 ||
                            r_state == S_SWAIT1 || r_state == S_SWAIT2))
        else $error("divider done outside a wait state");

    // game mode between ticks always has calibrated slopes
    a_game_slopes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_mode == MODE_GAME) |->
        (r_less_slope != '0 && r_more_slope != '0))
        else $error("game mode without slopes");

    // target never exceeds three quarters of full scale
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target <= FORCE_W'(768))
        else $error("target out of range");

endmodule

>>> design/ftl_div.sv
module ftl_div
    import ftl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ACC_W);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [ACC_W-1:0]        r_num;
    logic [DVS_W-2:0]        r_rem;
    logic [DVS_W-2:0]        r_den;
    logic                    r_neg;

    logic [ACC_W-1:0]        w_nmag;
    logic [DVS_W-1:0]        w_dabs;
    logic [DVS_W-1:0]        w_rem_sh;
    logic [DVS_W-1:0]        w_diff;
    logic                    w_ge;

    // operand magnitudes, sign of the result handled at the end
    assign w_nmag = i_req.dividend[ACC_W-1] ? unsigned'(-i_req.dividend)
                                            : unsigned'(i_req.dividend);
    assign w_dabs = i_req.divisor[DVS_W-1] ? unsigned'(-i_req.divisor)
                                           : unsigned'(i_req.divisor);

    // one restoring step: shift in the next dividend bit, try subtract
    assign w_rem_sh = {r_rem, r_num[ACC_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACC_W - 1);
                r_num  <= w_nmag;
                r_rem  <= '0;
                r_den  <= w_dabs[DVS_W-2:0];
                r_neg  <= i_req.dividend[ACC_W-1] ^ i_req.divisor[DVS_W-1];
            end else if (r_busy) begin
                r_num <= {r_num[ACC_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DVS_W-2:0] : w_rem_sh[DVS_W-2:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // quotient truncated toward zero
    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        o_rsp.quot = r_neg ? -signed'(r_num) : signed'(r_num);
    end

endmodule

>>> test/force_target_led_feedback_core_tb.sv
module force_target_led_feedback_core_tb;
    import ftl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        MODE_STANDBY   = 2'd0,
        MODE_CALIBRATE = 2'd1,
        MODE_GAME      = 2'd2
    } fb_mode_e;

    typedef enum logic [1:0] {
        REG_BIAS   = 2'd0,
        REG_THRESH = 2'd1,
        REG_OFFSET = 2'd2,
        REG_SPARE  = 2'd3
    } fb_reg_e;

    typedef enum {ROW_TICK, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [LVL_W-1:0] less_lvl;
        logic [LVL_W-1:0] tgt_lvl;
        logic [LVL_W-1:0] more_lvl;
        logic [LVL_W-1:0] tgt_quarter;
        fb_mode_e         mode;
    } lamps_t;

    typedef struct {
        lamps_t pred;
        bit     fixed;
        lamps_t typed;
    } lamp_exp_t;

    // one directed step: a tick repeated reps times, or a register write
    typedef struct {
        row_kind_e kind;
        int        reps;
        int        a;
        int        b;
        bit        fixed;
        lamps_t    typed;
    } dir_row_t;

    localparam int RND_ITEMS    = 1850;
    localparam int QUIET_AFTER  = 1500;
    localparam int DRAIN_CYCLES = 80;
    localparam int FULL_SPAN    = 25500;

    // block ports
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [FORCE_W-1:0] i_force_sample = '0;
    logic               i_button_level = 1'b1;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [LVL_W-1:0]   o_less_level;
    logic [LVL_W-1:0]   o_target_level;
    logic [LVL_W-1:0]   o_more_level;
    logic [LVL_W-1:0]   o_target_out;
    logic [1:0]         o_mode;
    logic               i_cfg_we       = 1'b0;
    logic [1:0]         i_cfg_idx      = '0;
    logic [CFG_W-1:0]   i_cfg_data     = '0;

    // typed expectation travels with the payload of the tick it belongs to
    bit     row_fixed = 1'b0;
    lamps_t row_typed = '0;

    // feedback model state and registers
    fb_mode_e fb_mode;
    int       fb_phase, fb_press, fb_calib, fb_peak, fb_target;
    int       fb_less_slope, fb_more_slope;
    int       fb_lv[3];
    int       cf_bias, cf_thresh, cf_offset;

    lamp_exp_t lamp_q[$];
    dir_row_t  dir_tbl[$];

    int  err_cnt = 0;
    int  n_sent = 0, rnd_items = 0;
    int  n_calib = 0, n_game = 0, n_press = 0, n_writes = 0;
    bit  tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;

    force_target_led_feedback_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_force_sample (i_force_sample),
        .i_button_level (i_button_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_less_level   (o_less_level),
        .o_target_level (o_target_level),
        .o_more_level   (o_more_level),
        .o_target_out   (o_target_out),
        .o_mode         (o_mode),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic lamps_t lamps(int less, int tgt, int more, int quarter, fb_mode_e m);
        lamps_t r;
        r.less_lvl    = less[LVL_W-1:0];
        r.tgt_lvl     = tgt[LVL_W-1:0];
        r.more_lvl    = more[LVL_W-1:0];
        r.tgt_quarter = quarter[LVL_W-1:0];
        r.mode        = m;
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] sat_level(longint v);
        if (v < 0) begin
            return '0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return v[LVL_W-1:0];
    endfunction

    // button debounce: true when the pressed count passes the threshold
    function automatic bit press_taken(logic btn);
        if (btn == 1'b0 && fb_press < 255) fb_press++;
        if (fb_press > cf_thresh) begin
            fb_press = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_calibration();
        fb_peak  = 0;
        fb_calib = 0;
        fb_mode  = MODE_CALIBRATE;
        n_press++;
    endfunction

    // advance the model by one tick and return the light levels it shows
    function automatic lamps_t next_lamps(logic [FORCE_W-1:0] f, logic btn);
        longint err, off, bias;
        int     span_hi, span_lo;
        int     mirror;
        mirror   = sat_level((longint'(f) + 3) / 4);
        fb_phase = (fb_phase + 1 >= 20) ? 0 : fb_phase + 1;
        case (fb_mode)
            MODE_CALIBRATE: begin
                if (fb_calib < 255) fb_calib++;
                if (int'(f) > fb_peak) fb_peak = int'(f);
                fb_lv[0] = mirror;
                fb_lv[1] = mirror;
                fb_lv[2] = mirror;
                if (fb_calib >= CALIB_TICKS_DEF) begin
                    fb_target = ((3 * fb_peak + 3) / 4) & 'h3FF;
                    span_hi   = fb_target - cf_bias;
                    span_lo   = fb_target - 1024;
                    if (span_hi == 0) span_hi = 1;
                    if (span_lo == 0) span_lo = 1;
                    fb_more_slope = FULL_SPAN / span_hi;
                    fb_less_slope = FULL_SPAN / span_lo;
                    fb_mode       = MODE_GAME;
                    n_calib++;
                end
            end
            MODE_GAME: begin
                err  = longint'(fb_target) - longint'(f);
                off  = longint'(cf_offset);
                bias = longint'(cf_bias);
                if (err < 0) begin
                    fb_lv[1] = sat_level((-longint'(fb_less_slope) * err + off + 99) / 100);
                    fb_lv[0] = sat_level((longint'(fb_less_slope) * err + 99) / 100 - bias);
                    fb_lv[2] = 0;
                end else begin
                    fb_lv[1] = sat_level((-longint'(fb_more_slope) * err + off + 99) / 100);
                    fb_lv[2] = sat_level((longint'(fb_more_slope) * err + 99) / 100 - bias);
                    fb_lv[0] = 0;
                end
                n_game++;
                if (press_taken(btn)) start_calibration();
            end
            default: begin
                // standby: mirror on the target light, less/more blink in turn
                fb_lv[1] = mirror;
                if (fb_phase % 10 == 0) begin
                    fb_lv[2] = 10;
                    fb_lv[0] = 0;
                end
                if (fb_phase == 0) begin
                    fb_lv[2] = 0;
                    fb_lv[0] = 10;
                end
                if (press_taken(btn)) begin
                    fb_lv[0] = 0;
                    fb_lv[1] = 0;
                    fb_lv[2] = 0;
                    start_calibration();
                end
            end
        endcase
        return lamps(fb_lv[0], fb_lv[1], fb_lv[2], fb_target / 4, fb_mode);
    endfunction

    function automatic void check_field(string what, string src,
                                        logic [LVL_W-1:0] exp_v, logic [LVL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch (%s): expected %0d, actual %0d",
                     $time, what, src, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    function automatic void check_lamps(lamps_t x, string src);
        check_field("less_level", src, x.less_lvl, o_less_level);
        check_field("target_level", src, x.tgt_lvl, o_target_level);
        check_field("more_level", src, x.more_lvl, o_more_level);
        check_field("target_out", src, x.tgt_quarter, o_target_out);
        check_field("mode", src, {6'd0, x.mode}, {6'd0, o_mode});
    endfunction

    // monitor: checks results, then follows register writes and accepted ticks
    always @(posedge i_clk) begin : monitor
        lamp_exp_t ent;
        if (!i_rst_n) begin
            fb_mode       = MODE_STANDBY;
            fb_phase      = 0;
            fb_press      = 0;
            fb_calib      = 0;
            fb_peak       = 1024;
            fb_target     = 500;
            fb_less_slope = 0;
            fb_more_slope = 0;
            fb_lv         = '{0, 0, 0};
            cf_bias       = 0;
            cf_thresh     = 25;
            cf_offset     = 0;
            lamp_q.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (lamp_q.size() == 0) begin
                    $display("%0t ns: result transaction with nothing expected", $time);
                    err_cnt++;
                end else begin
                    ent = lamp_q.pop_front();
                    check_lamps(ent.pred, "predicted");
                    if (ent.fixed) check_lamps(ent.typed, "table");
                end
            end
            if (i_cfg_we) begin
                n_writes++;
                case (fb_reg_e'(i_cfg_idx))
                    REG_BIAS:   cf_bias   = int'(i_cfg_data[FORCE_W-1:0]);
                    REG_THRESH: cf_thresh = int'(i_cfg_data[LVL_W-1:0]);
                    REG_OFFSET: cf_offset = int'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                ent.pred  = next_lamps(i_force_sample, i_button_level);
                ent.fixed = row_fixed;
                ent.typed = row_typed;
                lamp_q.push_back(ent);
            end
        end
    end

    // result side: random stall bursts
    always @(posedge i_clk) begin : sink
        int rx_hold;
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= (rx_hold == 0);
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // present one tick and hold it until the transaction completes
    task automatic send_tick(int f, int btn, bit fixed, lamps_t typed);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_force_sample <= f[FORCE_W-1:0];
        i_button_level <= btn[0];
        row_fixed      <= fixed;
        row_typed      <= typed;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    task automatic send_rnd(int f, int btn);
        send_tick(f, btn, 1'b0, '0);
        rnd_items++;
    endtask

    // register write, only once every outstanding result has come back
    task automatic cfg_write(fb_reg_e idx, int data);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (lamp_q.size() != 0);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic dir_row_t tick_row(int reps, int f, int btn, bit fixed, lamps_t t);
        dir_row_t r;
        r.kind  = ROW_TICK;
        r.reps  = reps;
        r.a     = f;
        r.b     = btn;
        r.fixed = fixed;
        r.typed = t;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(fb_reg_e idx, int data);
        dir_row_t r;
        r.kind  = ROW_CFG;
        r.reps  = 1;
        r.a     = int'(idx);
        r.b     = data;
        r.fixed = 1'b0;
        r.typed = '0;
        return r;
    endfunction

    initial begin : stim
        int peak_plan, tgt_plan, bias_v, thr_v, off_v, plen, n, k, f, btn;
        int offs[6];

        // standby: mirror levels and the blink pattern through a full cycle
        dir_tbl.push_back(tick_row(1, 0, 1, 1, lamps(0, 0, 0, 125, MODE_STANDBY)));
        dir_tbl.push_back(tick_row(1, 1023, 1, 1, lamps(0, 255, 0, 125, MODE_STANDBY)));
        dir_tbl.push_back(tick_row(1, 1, 1, 1, lamps(0, 1, 0, 125, MODE_STANDBY)));
        dir_tbl.push_back(tick_row(6, 1020, 1, 1, lamps(0, 255, 0, 125, MODE_STANDBY)));
        dir_tbl.push_back(tick_row(1, 512, 1, 1, lamps(0, 128, 10, 125, MODE_STANDBY)));
        dir_tbl.push_back(tick_row(9, 3, 1, 1, lamps(0, 1, 10, 125, MODE_STANDBY)));
        dir_tbl.push_back(tick_row(1, 4, 1, 1, lamps(10, 1, 0, 125, MODE_STANDBY)));
        // press from standby with the lowest threshold, full-scale peak
        dir_tbl.push_back(cfg_row(REG_THRESH, 0));
        dir_tbl.push_back(tick_row(1, 100, 0, 1, lamps(0, 0, 0, 125, MODE_CALIBRATE)));
        dir_tbl.push_back(tick_row(1, 1023, 1, 1, lamps(255, 255, 255, 125, MODE_CALIBRATE)));
        dir_tbl.push_back(tick_row(248, 0, 0, 1, lamps(0, 0, 0, 125, MODE_CALIBRATE)));
        dir_tbl.push_back(tick_row(1, 0, 1, 1, lamps(0, 0, 0, 192, MODE_GAME)));
        // game: on target, largest positive and negative error
        dir_tbl.push_back(tick_row(1, 768, 1, 1, lamps(0, 0, 0, 192, MODE_GAME)));
        dir_tbl.push_back(tick_row(1, 0, 1, 1, lamps(0, 0, 254, 192, MODE_GAME)));
        dir_tbl.push_back(tick_row(1, 1023, 1, 1, lamps(253, 0, 0, 192, MODE_GAME)));
        dir_tbl.push_back(cfg_row(REG_OFFSET, 25500));
        dir_tbl.push_back(tick_row(1, 768, 1, 1, lamps(0, 255, 0, 192, MODE_GAME)));
        // press during game keeps this tick's levels
        dir_tbl.push_back(tick_row(1, 700, 0, 0, '0));
        // bias equal to the new target: zero span on the more side
        dir_tbl.push_back(cfg_row(REG_BIAS, 750));
        dir_tbl.push_back(tick_row(249, 1000, 1, 1, lamps(250, 250, 250, 192, MODE_CALIBRATE)));
        dir_tbl.push_back(tick_row(1, 1000, 1, 1, lamps(250, 250, 250, 187, MODE_GAME)));
        dir_tbl.push_back(tick_row(1, 0, 1, 1, lamps(0, 0, 255, 187, MODE_GAME)));
        dir_tbl.push_back(tick_row(1, 1023, 1, 0, '0));
        // saturated threshold: the count pins at 255 and never fires
        dir_tbl.push_back(cfg_row(REG_THRESH, 255));
        dir_tbl.push_back(tick_row(300, 500, 0, 1, lamps(0, 0, 255, 187, MODE_GAME)));
        // lowering the threshold lets the stored count fire on a released tick
        dir_tbl.push_back(cfg_row(REG_THRESH, 0));
        dir_tbl.push_back(tick_row(1, 500, 1, 1, lamps(0, 0, 255, 187, MODE_CALIBRATE)));

        offs = '{-25500, 25500, -32768, 32767, 0, 1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                cfg_write(fb_reg_e'(dir_tbl[i].a), dir_tbl[i].b);
            end else begin
                repeat (dir_tbl[i].reps)
                    send_tick(dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].fixed, dir_tbl[i].typed);
            end
        end

        // random phases: settings, noise, press, calibration, game play
        while (rnd_items < RND_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       peak_plan = 1023;
                1:       peak_plan = 0;
                default: peak_plan = $urandom_range(0, 1023);
            endcase
            tgt_plan = (3 * peak_plan + 3) / 4;
            case ($urandom_range(0, 7))
                0, 1:    bias_v = tgt_plan;
                2:       bias_v = 0;
                3:       bias_v = 1023;
                default: bias_v = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 19))
                0:       thr_v = 254;
                1:       thr_v = 255;
                default: thr_v = $urandom_range(0, 6);
            endcase
            off_v = ($urandom_range(0, 1) == 0) ? offs[$urandom_range(0, 5)]
                                                : int'($urandom_range(0, 65535));
            cfg_write(REG_BIAS, bias_v);
            cfg_write(REG_THRESH, thr_v);
            cfg_write(REG_OFFSET, off_v);
            if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom_range(0, 65535));

            if (rnd_items >= QUIET_AFTER) begin
                tx_idle_en = 1'b0;
                rx_idle_en <= 1'b0;
            end else begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en <= ($urandom_range(0, 3) != 0);
            end

            n = $urandom_range(2, 20);
            repeat (n) send_rnd($urandom_range(0, 1023), ($urandom_range(0, 3) == 0) ? 0 : 1);

            plen = (thr_v >= 255) ? 40 : thr_v + 1;
            repeat (plen) send_rnd($urandom_range(0, 1023), 0);

            k = $urandom_range(0, CALIB_TICKS_DEF - 1);
            for (int i = 0; i < CALIB_TICKS_DEF; i++) begin
                f = (i == k) ? peak_plan : $urandom_range(0, peak_plan);
                send_rnd(f, $urandom_range(0, 1));
            end

            n = $urandom_range(20, 120);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0:       f = 0;
                    1:       f = 1023;
                    2, 3:    f = tgt_plan + $urandom_range(0, 40) - 20;
                    default: f = $urandom_range(0, 1023);
                endcase
                if (f < 0) f = 0;
                if (f > 1023) f = 1023;
                btn = ($urandom_range(0, 15) == 0) ? 0 : 1;
                send_rnd(f, btn);
            end
        end

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (lamp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d ticks: %0d game ticks, %0d calibrations, %0d presses,",
                 n_sent, n_game, n_calib, n_press);
        $display("with %0d register writes across standby, calibration and game play.",
                 n_writes);
        if (err_cnt == 0) begin
            $display("[force_target_led_feedback_core] OK");
        end else begin
            $display("[force_target_led_feedback_core] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", lamp_q.size());
        $display("[force_target_led_feedback_core] ERROR");
        $finish;
    end

endmodule
